>>> rtl/pitch_target_stabilizer_defines.svh
`ifndef PITCH_TARGET_STABILIZER_DEFINES_SVH
`define PITCH_TARGET_STABILIZER_DEFINES_SVH

// Plain property, checked on every rising edge outside reset.
`define PTS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define PTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pts_pkg.sv
package pts_pkg;

  localparam int COUNT_BITS    = 24;
  localparam int PITCH_W       = 15;
  localparam int SAMP_W        = 13;
  localparam int GAIN_W        = 16;
  localparam int GAIN_FRAC     = 15;
  localparam int SCFG_W        = 24;
  localparam int BLOCKS_W      = 8;
  localparam int MODE_W        = 3;
  localparam int CFG_W         = 24;
  localparam int CFG_IDX_W     = 3;
  localparam int DIV_CNT_W     = $clog2(GAIN_FRAC);
  localparam int CMP_W         = ((COUNT_BITS > SCFG_W) ? COUNT_BITS : SCFG_W) + 1;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [PITCH_W-1:0]    pitch_t;
  typedef logic [SCFG_W-1:0]     scfg_t;

  localparam cnt_t                CNT_MAX    = '1;
  localparam logic [GAIN_W-1:0]   UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC;
  localparam logic [BLOCKS_W-1:0] BLOCKS_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE    = 3'd0,
    MODE_ATTACK  = 3'd1,
    MODE_COLLECT = 3'd2,
    MODE_STABLE  = 3'd3,
    MODE_COAST   = 3'd4
  } mode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_SETTLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_HOLD    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_COAST_FADE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REACQUIRE     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_CONVERGE_TOL  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_TOL     = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_BLOCKS    = CFG_IDX_W'(6);

  typedef struct packed {
    logic                onset;
    logic                pitch_valid;
    logic [PITCH_W-1:0]  pitch_midi;
    logic [SAMP_W-1:0]   block_samples;
  } in_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                has_target;
    logic [PITCH_W-1:0]  target_midi;
    logic [GAIN_W-1:0]   fade_gain;
  } out_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic gain;
    logic div;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } sts_t;

endpackage

>>> rtl/pts_dp.sv
module pts_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pts_pkg::in_t                      in_data_i,
  input  logic                              cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pts_pkg::CFG_W-1:0]         cfg_data_i,
  input  pts_pkg::cmd_t                     cmd_i,
  output pts_pkg::sts_t                     sts_o,
  output pts_pkg::out_t                     out_data_o
);
  import pts_pkg::*;

  function automatic cnt_t sat_add(cnt_t a, logic [SAMP_W-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic pitch_t pdiff(pitch_t a, pitch_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  scfg_t               settle_q, hold_q, fade_q, reacq_q;
  pitch_t              ctol_q, ttol_q;
  logic [BLOCKS_W-1:0] req_q;

  in_t                 in_q;
  out_t                out_q;

  mode_e               mode_q, mode_d;
  cnt_t                time_q, time_d;
  pitch_t              last_q, last_d;
  logic [BLOCKS_W-1:0] cc_q, cc_d;
  cnt_t                dev_q, dev_d;
  logic                cand_q, cand_d;
  pitch_t              cpitch_q, cpitch_d;
  logic                tgt_q, tgt_d;
  pitch_t              tpitch_q, tpitch_d;

  logic [GAIN_W-1:0]   gain_q, gain_init;
  scfg_t               rem_q, rem_init;
  logic                need_div;
  logic [CMP_W-1:0]    t_ext, hold_ext, fade_ext, d_ext;
  logic [SCFG_W:0]     rem_dbl, rem_sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SCFG_W'(1440);
      hold_q   <= SCFG_W'(4800);
      fade_q   <= SCFG_W'(9600);
      reacq_q  <= SCFG_W'(4800);
      ctol_q   <= PITCH_W'(128);
      ttol_q   <= PITCH_W'(128);
      req_q    <= BLOCKS_W'(3);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ATTACK_SETTLE: settle_q <= cfg_data_i[SCFG_W-1:0];
        CFG_COAST_HOLD:    hold_q   <= cfg_data_i[SCFG_W-1:0];
        CFG_COAST_FADE:    fade_q   <= cfg_data_i[SCFG_W-1:0];
        CFG_REACQUIRE:     reacq_q  <= cfg_data_i[SCFG_W-1:0];
        CFG_CONVERGE_TOL:  ctol_q   <= cfg_data_i[PITCH_W-1:0];
        CFG_TRACK_TOL:     ttol_q   <= cfg_data_i[PITCH_W-1:0];
        CFG_REQ_BLOCKS:    req_q    <= cfg_data_i[BLOCKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d   = mode_q;
    time_d   = time_q;
    last_d   = last_q;
    cc_d     = cc_q;
    dev_d    = dev_q;
    cand_d   = cand_q;
    cpitch_d = cpitch_q;
    tgt_d    = tgt_q;
    tpitch_d = tpitch_q;
    if (in_q.onset && (mode_q == MODE_IDLE || mode_q == MODE_COAST)) begin
      mode_d = MODE_ATTACK;
      time_d = '0;
    end
    case (mode_d)
      MODE_IDLE: begin
        if (in_q.pitch_valid) begin
          mode_d = MODE_COLLECT;
          time_d = '0;
          cc_d   = '0;
        end
      end
      MODE_ATTACK: begin
        time_d = sat_add(time_d, in_q.block_samples);
        if (CMP_W'(time_d) >= CMP_W'(settle_q)) begin
          mode_d = MODE_COLLECT;
          time_d = '0;
          cc_d   = '0;
        end
      end
      MODE_COLLECT: begin
        time_d = sat_add(time_d, in_q.block_samples);
        if (in_q.pitch_valid) begin
          if (cc_q == '0 || pdiff(in_q.pitch_midi, last_q) <= ctol_q) begin
            if (cc_q != BLOCKS_MAX) begin
              cc_d = cc_q + BLOCKS_W'(1);
            end
          end else begin
            cc_d = BLOCKS_W'(1);
          end
          last_d = in_q.pitch_midi;
          if (cc_d >= req_q) begin
            tpitch_d = in_q.pitch_midi;
            tgt_d    = 1'b1;
            mode_d   = MODE_STABLE;
            time_d   = '0;
            dev_d    = '0;
            cand_d   = 1'b0;
            cpitch_d = '0;
          end
        end
      end
      MODE_STABLE: begin
        if (!in_q.pitch_valid) begin
          mode_d = MODE_COAST;
          time_d = '0;
        end else if (pdiff(in_q.pitch_midi, tpitch_q) <= ttol_q) begin
          tpitch_d = in_q.pitch_midi;
          dev_d    = '0;
          cand_d   = 1'b0;
          cpitch_d = '0;
        end else begin
          if (cand_q && pdiff(in_q.pitch_midi, cpitch_q) <= ctol_q) begin
            dev_d = sat_add(dev_q, in_q.block_samples);
          end else begin
            cand_d = 1'b1;
            dev_d  = COUNT_BITS'(in_q.block_samples);
          end
          cpitch_d = in_q.pitch_midi;
          if (CMP_W'(dev_d) >= CMP_W'(reacq_q)) begin
            last_d = in_q.pitch_midi;
            mode_d = MODE_COLLECT;
            time_d = '0;
            cc_d   = '0;
          end
        end
      end
      MODE_COAST: begin
        if (in_q.pitch_valid) begin
          mode_d   = MODE_STABLE;
          time_d   = '0;
          dev_d    = '0;
          cand_d   = 1'b0;
          cpitch_d = '0;
        end else begin
          time_d = sat_add(time_d, in_q.block_samples);
          if (CMP_W'(time_d) > CMP_W'(hold_q) + CMP_W'(fade_q)) begin
            tgt_d  = 1'b0;
            mode_d = MODE_IDLE;
            time_d = '0;
          end
        end
      end
      default: begin
        mode_d = MODE_IDLE;
      end
    endcase
  end

  assign t_ext    = CMP_W'(time_q);
  assign hold_ext = CMP_W'(hold_q);
  assign fade_ext = CMP_W'(fade_q);
  assign d_ext    = t_ext - hold_ext;
  assign rem_init = fade_q - d_ext[SCFG_W-1:0];

  always_comb begin
    gain_init = '0;
    need_div  = 1'b0;
    case (mode_q)
      MODE_ATTACK, MODE_COLLECT: gain_init = tgt_q ? UNITY_GAIN : '0;
      MODE_STABLE:               gain_init = UNITY_GAIN;
      MODE_COAST: begin
        if (t_ext <= hold_ext) begin
          gain_init = UNITY_GAIN;
        end else if (fade_q != '0 && d_ext < fade_ext) begin
          need_div = 1'b1;
        end
      end
      default: gain_init = '0;
    endcase
  end

  assign sts_o.need_div = need_div;

  assign rem_dbl = {rem_q, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, fade_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      time_q   <= '0;
      last_q   <= '0;
      cc_q     <= '0;
      dev_q    <= '0;
      cand_q   <= 1'b0;
      cpitch_q <= '0;
      tgt_q    <= 1'b0;
      tpitch_q <= '0;
    end else if (cmd_i.step) begin
      mode_q   <= mode_d;
      time_q   <= time_d;
      last_q   <= last_d;
      cc_q     <= cc_d;
      dev_q    <= dev_d;
      cand_q   <= cand_d;
      cpitch_q <= cpitch_d;
      tgt_q    <= tgt_d;
      tpitch_q <= tpitch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
    if (cmd_i.gain) begin
      gain_q <= gain_init;
      rem_q  <= rem_init;
    end else if (cmd_i.div) begin
      if (rem_dbl >= {1'b0, fade_q}) begin
        rem_q  <= rem_sub[SCFG_W-1:0];
        gain_q <= {gain_q[GAIN_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_dbl[SCFG_W-1:0];
        gain_q <= {gain_q[GAIN_W-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_q.mode        <= mode_q;
      out_q.has_target  <= tgt_q;
      out_q.target_midi <= tpitch_q;
      out_q.fade_gain   <= gain_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> rtl/pts_ctrl.sv
module pts_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  pts_pkg::sts_t  sts_i,
  output pts_pkg::cmd_t  cmd_o
);
  import pts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_GAIN,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                state_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  out_valid_q;
  logic                  load;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign load           = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign cmd_o.capture  = in_ready_o && in_valid_i;
  assign cmd_o.step     = (state_q == ST_STEP);
  assign cmd_o.gain     = (state_q == ST_GAIN);
  assign cmd_o.div      = (state_q == ST_DIV);
  assign cmd_o.out_load = load;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load || (out_valid_q && !out_ready_i);
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_STEP;
          end
        end
        ST_STEP: state_q <= ST_GAIN;
        ST_GAIN: begin
          cnt_q   <= '0;
          state_q <= sts_i.need_div ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + DIV_CNT_W'(1);
          if (cnt_q == DIV_CNT_W'(GAIN_FRAC - 1)) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pitch_target_stabilizer.sv
// Pitch target stabilizer: one report per analysis block in, one result out.
// Input channel in_valid_i/in_ready_o carries onset, pitch_valid, pitch_midi
// (Q7.8) and block_samples. Output channel out_valid_o/out_ready_i carries
// mode, has_target, target_midi (Q7.8) and fade_gain (Q1.15, 32768 = unity).
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
// high; write only while no item is in flight. Indexes above 6 are ignored.
// Sequence: the input is captured, the state is stepped and the gain is set;
// while the coast fade is running, a restoring divider then forms the 15
// fraction bits of the gain one bit per cycle; then the result is loaded.
// A new item is taken only once the previous result has been loaded.
// The result sits in an output register; the next item is taken while it
// waits. A stalled receiver holds the result, and the following item then
// waits in the controller until the output register frees.
// Reset: state machine to idle, counters and target cleared, registers to
// their defaults (settle 1440, hold 4800, fade 9600, reacquire 4800,
// tolerances 128, required blocks 3).
module pitch_target_stabilizer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pts_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pts_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pts_pkg::CFG_W-1:0]      cfg_data_i
);
  import pts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pts_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> rtl/pts_chk.sv
`include "pitch_target_stabilizer_defines.svh"

module pts_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_o,
  input  logic           out_valid_o,
  input  logic           out_ready_i,
  input  pts_pkg::out_t  out_data_o
);
  import pts_pkg::*;

  logic in_xfer;
  logic stall;
  logic out_stable;
  logic stable_ok;
  logic out_idle;
  logic idle_ok;
  logic gain_ok;

  assign in_xfer    = in_valid_i && in_ready_o;
  assign stall      = out_valid_o && !out_ready_i;
  assign out_stable = out_valid_o && (out_data_o.mode == MODE_STABLE);
  assign stable_ok  = out_data_o.has_target && (out_data_o.fade_gain == UNITY_GAIN);
  assign out_idle   = out_valid_o && (out_data_o.mode == MODE_IDLE);
  assign idle_ok    = !out_data_o.has_target && (out_data_o.fade_gain == '0);
  assign gain_ok    = !out_valid_o || (out_data_o.fade_gain <= UNITY_GAIN);

  `PTS_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall, out_valid_o && $stable(out_data_o), "result moved")
  `PTS_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_xfer, !in_ready_o, "second item taken")
  `PTS_ASSERT_IMPL(a_stable_unity, clk_i, rst_ni, out_stable, stable_ok, "stable gain wrong")
  `PTS_ASSERT_IMPL(a_idle_mute, clk_i, rst_ni, out_idle, idle_ok, "idle with target or gain")
  `PTS_ASSERT(a_gain_range, clk_i, rst_ni, gain_ok, "gain above unity")

endmodule

bind pitch_target_stabilizer pts_chk u_pts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
